// ----- hdl/srgb_alpha_compose_premultiply_unit_defines.svh -----
// Assertion macros shared by the checker of the sRGB alpha compose unit.
`ifndef SRGB_ALPHA_COMPOSE_PREMULTIPLY_UNIT_DEFINES_SVH
`define SRGB_ALPHA_COMPOSE_PREMULTIPLY_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, ignored while arst_n is low.
`define SACP_ASSERT_NOW(name, cond, prop) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error("sacp checker: same-cycle property failed");

// Next-cycle implication, sampled on clk, ignored while arst_n is low.
`define SACP_ASSERT_NEXT(name, cond, prop) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error("sacp checker: next-cycle property failed");

`endif

// ----- hdl/sacp_pkg.sv -----
// Package: types, register codes and ROM builders of the sRGB alpha compose unit.
`timescale 1ns / 1ps
package sacp_pkg;

	localparam int LINEAR_INDEX_BITS_DEF = 10;
	localparam int CFG_INDEX_W = 4;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_INDEX_W-1:0] REG_ALPHA_MODE = CFG_INDEX_W'(0);
	localparam logic [CFG_INDEX_W-1:0] REG_COMPOSE_COLOR = CFG_INDEX_W'(1);

	typedef enum logic [1:0] {
		MODE_OWN     = 2'd0,
		MODE_BYTE    = 2'd1,
		MODE_COMPOSE = 2'd2
	} alpha_mode_e;

	localparam logic [1:0] ALPHA_MODE_RESET = MODE_OWN;
	localparam logic [23:0] COMPOSE_RESET = 24'hFFFFFF;

	typedef struct packed {
		logic [1:0]  alpha_mode;
		logic [23:0] compose_color;
	} cfg_t;

	// lin_c[2] red, lin_c[1] green, lin_c[0] blue
	typedef struct packed {
		logic [7:0]       a8;
		logic [15:0]      lin_a;
		logic [2:0][15:0] lin_c;
	} lin_t;

	localparam int BIG_W = 384;
	localparam int unsigned GAMMA_DEN = 269025;
	localparam longint LIN_DEN = 255 * 1292;

	typedef logic [255:0][15:0] lin_rom_t;

	// a^ea * b^eb as a wide unsigned integer
	function automatic logic [BIG_W-1:0] big_pow(logic [31:0] a, int unsigned ea,
			logic [31:0] b, int unsigned eb);
		logic [BIG_W-1:0] r;
		logic [BIG_W-1:0] f;
		r = BIG_W'(1);
		for (int unsigned k = 0; k < ea + eb; k++) begin
			f = (k < ea) ? BIG_W'(a) : BIG_W'(b);
			r = r * f;
		end
		return r;
	endfunction

	localparam logic [BIG_W-1:0] DEN12 = big_pow(GAMMA_DEN, 12, 32'd1, 0);

	function automatic lin_rom_t build_lin_rom();
		lin_rom_t rom;
		logic [BIG_W-1:0] lhs;
		logic [BIG_W-1:0] rhs;
		int unsigned lo;
		int unsigned hi;
		int unsigned mid;
		for (int i = 0; i < 256; i++) begin
			if (longint'(i) * 100000 <= longint'(4045 * 255)) begin
				rom[i] = 16'((longint'(i) * 65535 * 100) / LIN_DEN);
			end else begin
				rhs = big_pow(32'(1000 * i + 14025), 12, 32'd65535, 5);
				lo = 0;
				hi = 65535;
				while (lo < hi) begin
					mid = lo + ((hi - lo + 1) >> 1);
					lhs = big_pow(32'(mid), 5, 32'd1, 0) * DEN12;
					if (lhs <= rhs) begin
						lo = mid;
					end else begin
						hi = mid - 1;
					end
				end
				rom[i] = 16'(lo);
			end
		end
		return rom;
	endfunction

	localparam lin_rom_t LIN_ROM = build_lin_rom();

	// one entry of the linear-to-sRGB table, d = table size - 1
	function automatic logic [7:0] srgb_entry(int unsigned i, int unsigned d);
		logic [BIG_W-1:0] lhs;
		logic [BIG_W-1:0] rhs;
		longint lo;
		longint hi;
		longint mid;
		lo = 0;
		hi = 255;
		if (longint'(i) * 10000000 <= longint'(31308) * longint'(d)) begin
			while (lo < hi) begin
				mid = lo + ((hi - lo + 1) >> 1);
				if (mid * 100 * longint'(d) <= longint'(255 * 1292) * longint'(i)) begin
					lo = mid;
				end else begin
					hi = mid - 1;
				end
			end
		end else begin
			lhs = big_pow(32'(i), 5, 32'd1, 0) * DEN12;
			while (lo < hi) begin
				mid = lo + ((hi - lo + 1) >> 1);
				rhs = big_pow(32'(1000 * mid + 14025), 12, 32'(d), 5);
				if (lhs >= rhs) begin
					lo = mid;
				end else begin
					hi = mid - 1;
				end
			end
		end
		return 8'(lo);
	endfunction

endpackage

// ----- hdl/sacp_cfg_regs.sv -----
// Configuration registers: alpha mode and compose colour.
`timescale 1ns / 1ps
module sacp_cfg_regs
	import sacp_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_valid,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	output cfg_t                   cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.alpha_mode <= ALPHA_MODE_RESET;
			cfg_q.compose_color <= COMPOSE_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_ALPHA_MODE: cfg_q.alpha_mode <= cfg_data[1:0];
				REG_COMPOSE_COLOR: cfg_q.compose_color <= cfg_data[23:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- hdl/sacp_linearise.sv -----
// Input stage and sRGB-to-linear lookup of alpha and colour channels.
`timescale 1ns / 1ps
module sacp_linearise
	import sacp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] color_pixel,
	input  logic [7:0]  alpha_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output lin_t        out_lin
);

	logic        v_s1;
	logic        v_s2;
	logic        en_s1;
	logic        en_s2;
	logic [7:0]  a8_d;
	logic [23:0] rgb_d;
	logic [7:0]  a8_s1;
	logic [23:0] rgb_s1;
	lin_t        lin_s2;

	assign en_s2 = !v_s2 || out_ready;
	assign en_s1 = !v_s1 || en_s2;
	assign in_ready = en_s1;

	always_comb begin
		case (cfg.alpha_mode)
			MODE_BYTE: begin
				a8_d = alpha_byte;
				rgb_d = color_pixel[23:0];
			end
			MODE_COMPOSE: begin
				a8_d = alpha_byte;
				rgb_d = cfg.compose_color;
			end
			default: begin
				a8_d = color_pixel[31:24];
				rgb_d = color_pixel[23:0];
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (en_s1) begin
				v_s1 <= in_valid;
			end
			if (en_s2) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			a8_s1 <= a8_d;
			rgb_s1 <= rgb_d;
		end
		if (en_s2) begin
			lin_s2.a8 <= a8_s1;
			lin_s2.lin_a <= LIN_ROM[a8_s1];
			lin_s2.lin_c[2] <= LIN_ROM[rgb_s1[23:16]];
			lin_s2.lin_c[1] <= LIN_ROM[rgb_s1[15:8]];
			lin_s2.lin_c[0] <= LIN_ROM[rgb_s1[7:0]];
		end
	end

	assign out_valid = v_s2;
	assign out_lin = lin_s2;

endmodule

// ----- hdl/sacp_premul.sv -----
// Premultiply by linear alpha and linear-to-sRGB lookup, result register.
`timescale 1ns / 1ps
module sacp_premul
	import sacp_pkg::*;
#(
	parameter int LINEAR_INDEX_BITS = LINEAR_INDEX_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  lin_t        in_lin,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] out_pixel
);

	localparam int SRGB_SIZE = 1 << LINEAR_INDEX_BITS;

	typedef logic [SRGB_SIZE-1:0][7:0] srgb_rom_t;

	function automatic srgb_rom_t build_srgb_rom();
		srgb_rom_t rom;
		for (int i = 0; i < SRGB_SIZE; i++) begin
			rom[i] = srgb_entry(i, SRGB_SIZE - 1);
		end
		return rom;
	endfunction

	localparam srgb_rom_t SRGB_ROM = build_srgb_rom();

	logic                              v_s3;
	logic                              v_s4;
	logic                              en_s3;
	logic                              en_s4;
	logic [7:0]                        a8_s3;
	logic [7:0]                        a8_s4;
	logic [2:0][LINEAR_INDEX_BITS-1:0] idx_s3;
	logic [2:0][7:0]                   srgb_s4;

	assign en_s4 = !v_s4 || out_ready;
	assign en_s3 = !v_s3 || en_s4;
	assign in_ready = en_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en_s3) begin
				v_s3 <= in_valid;
			end
			if (en_s4) begin
				v_s4 <= v_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3) begin
			a8_s3 <= in_lin.a8;
		end
		if (en_s4) begin
			a8_s4 <= a8_s3;
		end
	end

	for (genvar c = 0; c < 3; c++) begin : g_chan
		logic [31:0] prod;

		assign prod = 32'(in_lin.lin_a) * 32'(in_lin.lin_c[c]);

		always_ff @(posedge clk) begin
			if (en_s3) begin
				idx_s3[c] <= prod[31 -: LINEAR_INDEX_BITS];
			end
			if (en_s4) begin
				srgb_s4[c] <= SRGB_ROM[idx_s3[c]];
			end
		end
	end

	assign out_valid = v_s4;
	assign out_pixel = {a8_s4, srgb_s4[2], srgb_s4[1], srgb_s4[0]};

endmodule

// ----- hdl/srgb_alpha_compose_premultiply_unit.sv -----
// Top level of the sRGB alpha compose and linear premultiply unit.
// An input request passes through registers s1, s2, s3 and s4 before its result reaches the master side.
// Throughput: one pixel per cycle while m_tready is high; the four pipeline stages advance independently.
// The linear-to-sRGB table is a ROM with one registered read port per colour channel.
// Reset clears the stage valid bits, sets alpha_mode to 0 and compose_color to 0xFFFFFF.
// Configuration requests are always taken.
`timescale 1ns / 1ps
module srgb_alpha_compose_premultiply_unit
	import sacp_pkg::*;
#(
	parameter int LINEAR_INDEX_BITS = LINEAR_INDEX_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [39:0]            s_tdata,   // [31:0] color_pixel, [39:32] alpha_byte
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [31:0]            m_tdata,   // [31:0] out_pixel
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	cfg_t cfg;
	lin_t lin;
	logic lin_valid;
	logic lin_ready;

	assign cfg_ready = 1'b1;

	sacp_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	sacp_linearise u_lin (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.in_valid    (s_tvalid),
		.in_ready    (s_tready),
		.color_pixel (s_tdata[31:0]),
		.alpha_byte  (s_tdata[39:32]),
		.out_valid   (lin_valid),
		.out_ready   (lin_ready),
		.out_lin     (lin)
	);

	sacp_premul #(
		.LINEAR_INDEX_BITS (LINEAR_INDEX_BITS)
	) u_premul (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (lin_valid),
		.in_ready  (lin_ready),
		.in_lin    (lin),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_pixel (m_tdata)
	);

endmodule

// ----- hdl/sacp_checker.sv -----
// Port-level checker of the sRGB alpha compose unit and its bind.
`timescale 1ns / 1ps
`include "srgb_alpha_compose_premultiply_unit_defines.svh"
module sacp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata
);

	`SACP_ASSERT_NEXT(a_out_valid_holds, m_tvalid && !m_tready, m_tvalid)
	`SACP_ASSERT_NEXT(a_out_data_holds, m_tvalid && !m_tready, $stable(m_tdata))
	`SACP_ASSERT_NEXT(a_latency, (s_tvalid && s_tready) ##1 m_tready ##1 m_tready ##1 m_tready, m_tvalid)
	`SACP_ASSERT_NOW(a_zero_alpha_black, m_tvalid && (m_tdata[31:24] == 8'd0), m_tdata[23:0] == 24'd0)

endmodule

bind srgb_alpha_compose_premultiply_unit sacp_checker u_sacp_checker (.*);
